// ----- rtl/core/dwsm_pkg.sv -----
// Types, codes and helpers shared by the watchpoint slot manager.
package dwsm_pkg;

  localparam int HW_SLOTS = 4;
  localparam int SLOT_W   = 2;
  localparam int ADDR_W   = 64;
  localparam int DR7_W    = 32;

  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_SIZE     = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic [1:0] LEN_1B = 2'h0;
  localparam logic [1:0] LEN_2B = 2'h1;
  localparam logic [1:0] LEN_8B = 2'h2;
  localparam logic [1:0] LEN_4B = 2'h3;

  localparam logic [1:0] COND_WRITE = 2'h1;
  localparam logic [1:0] COND_RW    = 2'h3;

  localparam int DR7_COND_BASE = 16;
  localparam int DR7_LEN_BASE  = 18;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] watch_addr;
    logic              access_rw;
    logic [7:0]        size_bytes;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot_used;
    logic [ADDR_W-1:0] dr0_addr;
    logic [ADDR_W-1:0] dr1_addr;
    logic [ADDR_W-1:0] dr2_addr;
    logic [ADDR_W-1:0] dr3_addr;
    logic [DR7_W-1:0]  dr7_word;
  } rsp_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] code;
  } len_t;

  function automatic len_t len_decode(input logic [7:0] bytes);
    len_t r;
    r.ok   = 1'b1;
    r.code = LEN_1B;
    unique case (bytes)
      8'd1:    r.code = LEN_1B;
      8'd2:    r.code = LEN_2B;
      8'd4:    r.code = LEN_4B;
      8'd8:    r.code = LEN_8B;
      default: r.ok   = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/dwsm_if.sv -----
// Request and response channel interfaces of the watchpoint slot manager.
interface dwsm_req_if;
  logic          valid;
  logic          ready;
  dwsm_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dwsm_rsp_if;
  logic          valid;
  logic          ready;
  dwsm_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/debug_watchpoint_slot_manager_top.sv -----
// Top level of the watchpoint slot manager: slot store, command decode, DR7 build.
//
//   channel | dir | beat
//   --------+-----+------------------------------------------------------
//   req     | in  | cmd, watch_addr, access_rw, size_bytes
//   rsp     | out | status, slot_used, dr0_addr..dr3_addr, dr7_word
//
// One command per cycle while rsp is not stalled: a beat lands in the input
// register and is resolved against the slots, and its response registered,
// once the output can advance. rsp.valid follows in_vld, then out_vld; the
// slot compare and lowest-index pick set the path between the two registers.
// Reset empties every slot and clears the valid bit of both registers.
// A stalled rsp holds its beat; one more command waits, then req.ready drops.
module debug_watchpoint_slot_manager_top #(
  parameter int NUM_SLOTS = 4
) (
  input  logic        clk,
  input  logic        rst,
  dwsm_req_if.sink    req,
  dwsm_rsp_if.source  rsp
);

  logic                           in_vld;
  dwsm_pkg::req_t                 in_q;
  logic                           advance;
  logic                           proc;

  logic [NUM_SLOTS-1:0]           slot_valid;
  logic [NUM_SLOTS-1:0]           slot_valid_next;
  logic [dwsm_pkg::ADDR_W-1:0]    slot_addr [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]           slot_rw;
  logic [1:0]                     slot_len [NUM_SLOTS];

  logic                           free_found;
  logic [dwsm_pkg::SLOT_W-1:0]    free_idx;
  logic                           dup;
  logic                           hit_found;
  logic [dwsm_pkg::SLOT_W-1:0]    hit_idx;
  dwsm_pkg::len_t                 len;
  logic                           do_set;
  logic [2:0]                     status_next;
  logic [dwsm_pkg::SLOT_W-1:0]    slot_next;

  logic [dwsm_pkg::ADDR_W-1:0]    wr_addr [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]           wr_rw;
  logic [1:0]                     wr_len [NUM_SLOTS];
  logic [dwsm_pkg::ADDR_W-1:0]    dr_vis [dwsm_pkg::HW_SLOTS];
  logic [dwsm_pkg::DR7_W-1:0]     dr7_next;
  dwsm_pkg::rsp_t                 rsp_next;

  logic                           out_vld;
  dwsm_pkg::rsp_t                 out_q;

  assign advance   = !out_vld || rsp.ready;
  assign proc      = in_vld && advance;
  assign req.ready = !in_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req.ready) begin
      in_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_q <= req.data;
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    dup        = 1'b0;
    hit_found  = 1'b0;
    hit_idx    = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (slot_valid[s]) begin
        if (slot_addr[s] == in_q.watch_addr) begin
          dup = 1'b1;
          if (!hit_found) begin
            hit_found = 1'b1;
            hit_idx   = dwsm_pkg::SLOT_W'(s);
          end
        end
      end else if (!free_found) begin
        free_found = 1'b1;
        free_idx   = dwsm_pkg::SLOT_W'(s);
      end
    end
  end

  assign len = dwsm_pkg::len_decode(in_q.size_bytes);

  always_comb begin
    status_next     = dwsm_pkg::ST_OK;
    slot_next       = '0;
    do_set          = 1'b0;
    slot_valid_next = slot_valid;
    unique case (in_q.cmd)
      dwsm_pkg::CMD_SET: begin
        priority if (!free_found) begin
          status_next = dwsm_pkg::ST_FULL;
        end else if (dup) begin
          status_next = dwsm_pkg::ST_DUP;
        end else if (!len.ok) begin
          status_next = dwsm_pkg::ST_SIZE;
        end else begin
          do_set    = 1'b1;
          slot_next = free_idx;
          slot_valid_next[free_idx] = 1'b1;
        end
      end
      dwsm_pkg::CMD_REMOVE: begin
        if (hit_found) begin
          slot_next = hit_idx;
          slot_valid_next[hit_idx] = 1'b0;
        end else begin
          status_next = dwsm_pkg::ST_NOTFOUND;
        end
      end
      dwsm_pkg::CMD_CLEAR: begin
        slot_valid_next = '0;
      end
      default: begin
        slot_valid_next = slot_valid;
      end
    endcase
  end

  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (do_set && free_idx == dwsm_pkg::SLOT_W'(s)) begin
        wr_addr[s] = in_q.watch_addr;
        wr_rw[s]   = in_q.access_rw;
        wr_len[s]  = len.code;
      end else begin
        wr_addr[s] = slot_addr[s];
        wr_rw[s]   = slot_rw[s];
        wr_len[s]  = slot_len[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (proc) begin
      slot_valid <= slot_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      for (int s = 0; s < NUM_SLOTS; s++) begin
        slot_addr[s] <= wr_addr[s];
        slot_len[s]  <= wr_len[s];
      end
      slot_rw <= wr_rw;
    end
  end

  for (genvar g = 0; g < dwsm_pkg::HW_SLOTS; g++) begin : g_vis
    if (g < NUM_SLOTS) begin : g_live
      assign dr_vis[g] = slot_valid_next[g] ? wr_addr[g] : '0;
    end else begin : g_none
      assign dr_vis[g] = '0;
    end
  end

  always_comb begin
    dr7_next = '0;
    for (int s = 0; s < NUM_SLOTS; s++) begin
      if (slot_valid_next[s]) begin
        dr7_next[2*s] = 1'b1;
        dr7_next[dwsm_pkg::DR7_COND_BASE + 4*s +: 2] =
          wr_rw[s] ? dwsm_pkg::COND_RW : dwsm_pkg::COND_WRITE;
        dr7_next[dwsm_pkg::DR7_LEN_BASE + 4*s +: 2] = wr_len[s];
      end
    end
  end

  always_comb begin
    rsp_next.status    = status_next;
    rsp_next.slot_used = slot_next;
    rsp_next.dr0_addr  = dr_vis[0];
    rsp_next.dr1_addr  = dr_vis[1];
    rsp_next.dr2_addr  = dr_vis[2];
    rsp_next.dr3_addr  = dr_vis[3];
    rsp_next.dr7_word  = dr7_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_q <= rsp_next;
    end
  end

  assign rsp.valid = out_vld;
  assign rsp.data  = out_q;

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (proc && in_q.cmd == dwsm_pkg::CMD_CLEAR) |=> slot_valid == '0)
    else $error("remove-all left a slot in use");

  a_fail_no_slot: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_q.status != dwsm_pkg::ST_OK) |-> out_q.slot_used == '0)
    else $error("failed command reports a slot");

  a_set_grows: assert property (@(posedge clk) disable iff (rst)
    (proc && do_set) |=> $countones(slot_valid) == $past($countones(slot_valid)) + 1)
    else $error("successful set did not take exactly one slot");

  a_hold_pending: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !advance) |=> (in_vld && $stable(in_q)))
    else $error("pending command lost while response stalled");

endmodule
